@@ rtl/rcat_pkg.sv @@
// Shared types and constants for the reference count aging table.
`default_nettype none

package rcat_pkg;

	// Operation codes of a command beat.
	localparam logic OP_REFERENCE = 1'b0;
	localparam logic OP_CLEAN     = 1'b1;

	// Result status codes.
	localparam logic [1:0] STATUS_DONE     = 2'd0;
	localparam logic [1:0] STATUS_HIGH_REF = 2'd1;
	localparam logic [1:0] STATUS_LOW_REF  = 2'd2;

	// Configuration register indexes.
	localparam logic REG_HIGH_MARK = 1'b0;
	localparam logic REG_LOW_MARK  = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [5:0] HIGH_MARK_RESET = 6'd32;
	localparam logic [4:0] LOW_MARK_RESET  = 5'd16;

	// Saturation limit of a reference count.
	localparam logic [15:0] REFS_MAX = 16'hFFFF;

	// Command beat.
	typedef struct packed {
		logic               operation;
		logic signed [31:0] key;
		logic               check_mark;
	} cmd_t;

	// Result beat.
	typedef struct packed {
		logic [1:0]  status;
		logic        hit;
		logic [15:0] new_refs;
		logic [5:0]  entries;
		logic [5:0]  removed;
	} result_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WORK,
		ST_COUNT
	} state_t;

	// Strobes from the controller to every cell of the row.
	typedef struct packed {
		logic ref_en;
		logic clean_en;
		logic shift_en;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/rcat_cell.sv @@
// One table slot: key, reference count, valid bit and the chain links to its neighbors.
`default_nettype none

module rcat_cell
	import rcat_pkg::*;
#(
	parameter int KEY_BITS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cell_ctrl_t          ctrl,
	input  wire logic [KEY_BITS-1:0] key,
	input  wire logic                any_hit,
	input  wire logic                hit_in,
	input  wire logic                free_in,
	input  wire logic [15:0]         refs_in,
	input  wire logic                drop_in,
	output logic                     hit_out,
	output logic                     free_out,
	output logic [15:0]              refs_out,
	output logic                     drop_out
);

	logic                valid_q;
	logic                drop_q;
	logic [KEY_BITS-1:0] key_q;
	logic [15:0]         refs_q;
	logic                match;
	logic                take_slot;
	logic [15:0]         refs_inc;

	// Compare against the broadcast key and extend the chains.
	assign match     = valid_q && (key_q == key);
	assign hit_out   = hit_in | match;
	assign free_out  = free_in | ~valid_q;
	assign take_slot = ~valid_q && ~free_in;
	assign refs_inc  = (refs_q == REFS_MAX) ? refs_q : refs_q + 16'd1;
	assign refs_out  = match ? refs_inc : refs_in;
	assign drop_out  = drop_q;

	// Valid bit and drop flag; the drop flags form a shift line toward the row's end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			drop_q  <= 1'b0;
		end else if (ctrl.ref_en) begin
			if (!any_hit && take_slot) begin
				valid_q <= 1'b1;
			end
		end else if (ctrl.clean_en) begin
			if (valid_q && refs_q <= 16'd1) begin
				valid_q <= 1'b0;
				drop_q  <= 1'b1;
			end else begin
				drop_q  <= 1'b0;
			end
		end else if (ctrl.shift_en) begin
			drop_q <= drop_in;
		end
	end

	// Key and count payload.
	always_ff @(posedge clk) begin
		if (ctrl.ref_en) begin
			if (any_hit && match) begin
				refs_q <= refs_inc;
			end else if (!any_hit && take_slot) begin
				key_q  <= key;
				refs_q <= 16'd1;
			end
		end else if (ctrl.clean_en && valid_q) begin
			refs_q <= refs_q - 16'd1;
		end
	end

endmodule

`default_nettype wire

@@ rtl/reference_count_aging_table.sv @@
// Top level of the reference count aging table: controller and row of slot cells.
// A reference beat is captured when accepted; the row updates from the work state,
// and done is registered from that state. A cleaning beat that runs goes on to the
// count state, which shifts the drop flags out of the row one cell per cycle to count
// them; a refused cleaning beat ends in the work state. A new command is accepted in
// the cycle done is high; results cannot be stalled.
// Reset clears all valid bits and the entry count, and loads the mark registers.
`default_nettype none

module reference_count_aging_table
	import rcat_pkg::*;
#(
	parameter int CAPACITY = 32,
	parameter int KEY_BITS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire cmd_t       cmd,
	output logic            busy,
	output logic            done,
	output result_t         result,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [5:0] cfg_data
);

	localparam int TOT_W = $clog2(CAPACITY + 1);
	localparam int CNT_W = $clog2(CAPACITY);
	localparam int CMP_W = (TOT_W > 6) ? TOT_W : 6;

	state_t              state_q;
	state_t              state_d;
	cell_ctrl_t          ctrl;
	logic                op_q;
	logic                check_q;
	logic [KEY_BITS-1:0] key_q;
	logic [63:0]         key_wide;
	logic [5:0]          high_q;
	logic [4:0]          low_q;
	logic [TOT_W-1:0]    total_q;
	logic [TOT_W-1:0]    removed_q;
	logic [TOT_W-1:0]    removed_next;
	logic [CNT_W-1:0]    cnt_q;
	logic                count_last;
	logic                ref_refuse;
	logic                clean_refuse;
	logic                done_q;
	logic                done_d;
	result_t             result_q;
	result_t             result_d;
	logic [CMP_W-1:0]    total_ext;

	logic [CAPACITY:0]   hit_chain;
	logic [CAPACITY:0]   free_chain;
	logic [CAPACITY:0]   drop_chain;
	logic [15:0]         refs_chain [CAPACITY+1];

	// Sign-extend the key and keep its low KEY_BITS bits.
	assign key_wide = {{32{cmd.key[31]}}, cmd.key};

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q <= HIGH_MARK_RESET;
			low_q  <= LOW_MARK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HIGH_MARK: high_q <= cfg_data;
				REG_LOW_MARK:  low_q  <= cfg_data[4:0];
				default:       ;
			endcase
		end
	end

	// Command capture on an accepted beat.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q    <= cmd.operation;
			check_q <= cmd.check_mark;
			key_q   <= key_wide[KEY_BITS-1:0];
		end
	end

	// Refusal checks against the marks.
	assign total_ext    = CMP_W'(total_q);
	assign ref_refuse   = (total_ext >= CMP_W'(high_q)) || (total_q >= TOT_W'(CAPACITY));
	assign clean_refuse = check_q && (total_ext <= CMP_W'(low_q));
	assign removed_next = removed_q + TOT_W'(drop_chain[CAPACITY]);
	assign count_last   = (cnt_q == CNT_W'(CAPACITY - 1));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_WORK;
			end
			ST_WORK: begin
				if (op_q == OP_CLEAN && !clean_refuse) state_d = ST_COUNT;
				else state_d = ST_IDLE;
			end
			ST_COUNT: begin
				if (count_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Controller outputs.
	always_comb begin
		ctrl = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE:  busy = 1'b0;
			ST_WORK: begin
				ctrl.ref_en   = (op_q == OP_REFERENCE) && !ref_refuse;
				ctrl.clean_en = (op_q == OP_CLEAN) && !clean_refuse;
			end
			ST_COUNT: ctrl.shift_en = 1'b1;
			default:  busy = 1'b0;
		endcase
	end

	// The result beat follows a reference, a refusal, or the last count cycle.
	assign done_d = ((state_q == ST_WORK) && ((op_q == OP_REFERENCE) || clean_refuse))
		|| ((state_q == ST_COUNT) && count_last);

	// State, counters, entry count and the done strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			total_q   <= '0;
			removed_q <= '0;
			cnt_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			unique case (state_q)
				ST_WORK: begin
					removed_q <= '0;
					cnt_q     <= '0;
					if (op_q == OP_REFERENCE && !ref_refuse && !hit_chain[CAPACITY]) begin
						total_q <= total_q + TOT_W'(1);
					end
				end
				ST_COUNT: begin
					removed_q <= removed_next;
					cnt_q     <= cnt_q + CNT_W'(1);
					if (count_last) begin
						total_q <= total_q - removed_next;
					end
				end
				default: ;
			endcase
		end
	end

	// Result beat assembly.
	always_comb begin
		result_d = result_q;
		unique case (state_q)
			ST_WORK: begin
				result_d         = '0;
				result_d.entries = 6'(total_ext);
				if (op_q == OP_REFERENCE) begin
					if (ref_refuse) begin
						result_d.status = STATUS_HIGH_REF;
					end else if (hit_chain[CAPACITY]) begin
						result_d.hit      = 1'b1;
						result_d.new_refs = refs_chain[CAPACITY];
					end else begin
						result_d.new_refs = 16'd1;
						result_d.entries  = 6'(CMP_W'(total_q + TOT_W'(1)));
					end
				end else if (clean_refuse) begin
					result_d.status = STATUS_LOW_REF;
				end
			end
			ST_COUNT: begin
				if (count_last) begin
					result_d.removed = 6'(CMP_W'(removed_next));
					result_d.entries = 6'(CMP_W'(total_q - removed_next));
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

	assign done   = done_q;
	assign result = result_q;

	// Row of slot cells; the chains start empty at cell zero.
	assign hit_chain[0]  = 1'b0;
	assign free_chain[0] = 1'b0;
	assign drop_chain[0] = 1'b0;
	assign refs_chain[0] = 16'd0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_row
		rcat_cell #(
			.KEY_BITS(KEY_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.key      (key_q),
			.any_hit  (hit_chain[CAPACITY]),
			.hit_in   (hit_chain[i]),
			.free_in  (free_chain[i]),
			.refs_in  (refs_chain[i]),
			.drop_in  (drop_chain[i]),
			.hit_out  (hit_chain[i+1]),
			.free_out (free_chain[i+1]),
			.refs_out (refs_chain[i+1]),
			.drop_out (drop_chain[i+1])
		);
	end

endmodule

`default_nettype wire

@@ sim/reference_count_aging_table_test.sv @@
// Self-checking testbench for the reference count aging table with a shadow model.
`timescale 1ns / 1ps

module reference_count_aging_table_test;
	import rcat_pkg::*;

	localparam int TABLE_SLOTS  = 32;
	localparam int DRAIN_CYCLES = TABLE_SLOTS + 8;
	localparam int BURST_BEATS  = 40;
	localparam logic [31:0] BURST_KEY = 32'h5A5A_A5A5;

	// Shadow of the table: predicts each result beat and checks the ones the block returns.
	class refcount_shadow;
		logic        slot_valid [TABLE_SLOTS];
		logic [31:0] slot_key   [TABLE_SLOTS];
		logic [15:0] slot_refs  [TABLE_SLOTS];
		int          live_count;
		logic [5:0]  high_mark;
		logic [4:0]  low_mark;
		result_t     pending_results [$];
		int          mismatches;

		function new();
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				slot_valid[i] = 1'b0;
				slot_key[i]   = '0;
				slot_refs[i]  = '0;
			end
			live_count = 0;
			high_mark  = HIGH_MARK_RESET;
			low_mark   = LOW_MARK_RESET;
			mismatches = 0;
		endfunction

		function void write_register(logic index, logic [5:0] data);
			if (index == REG_HIGH_MARK) begin
				high_mark = data;
			end else begin
				low_mark = data[4:0];
			end
		endfunction

		// Apply one accepted command beat to the shadow and queue the result it must give.
		function void accept_command(cmd_t c);
			result_t r;
			int      slot;
			int      dropped;
			r = '0;
			slot = -1;
			dropped = 0;
			if (c.operation == OP_REFERENCE) begin
				// The mark check comes before the lookup, so a present key is refused too.
				if (live_count >= high_mark || live_count >= TABLE_SLOTS) begin
					r.status = STATUS_HIGH_REF;
				end else begin
					for (int i = 0; i < TABLE_SLOTS; i++) begin
						if (slot < 0 && slot_valid[i] && slot_key[i] == c.key) slot = i;
					end
					if (slot >= 0) begin
						if (slot_refs[slot] != REFS_MAX) slot_refs[slot] = slot_refs[slot] + 1'b1;
						r.hit = 1'b1;
						r.new_refs = slot_refs[slot];
					end else begin
						for (int i = 0; i < TABLE_SLOTS; i++) begin
							if (slot < 0 && !slot_valid[i]) slot = i;
						end
						slot_valid[slot] = 1'b1;
						slot_key[slot]   = c.key;
						slot_refs[slot]  = 16'd1;
						live_count++;
						r.new_refs = 16'd1;
					end
				end
			end else if (c.check_mark && live_count <= low_mark) begin
				r.status = STATUS_LOW_REF;
			end else begin
				// Age every live entry; a count that would reach zero drops the entry.
				for (int i = 0; i < TABLE_SLOTS; i++) begin
					if (slot_valid[i]) begin
						if (slot_refs[i] <= 16'd1) begin
							slot_valid[i] = 1'b0;
							slot_refs[i]  = '0;
							dropped++;
						end else begin
							slot_refs[i] = slot_refs[i] - 1'b1;
						end
					end
				end
				live_count = live_count - dropped;
				r.removed = 6'(dropped);
			end
			r.entries = 6'(live_count);
			pending_results.push_back(r);
		endfunction

		task flag_mismatch(string what);
			$display("[%0t] mismatch: %s", $time, what);
			mismatches++;
		endtask

		task compare_field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want) flag_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
		endtask

		task check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				flag_mismatch("result beat with no command outstanding");
				return;
			end
			want = pending_results.pop_front();
			compare_field("status", got.status, want.status);
			compare_field("hit", got.hit, want.hit);
			compare_field("new_refs", got.new_refs, want.new_refs);
			compare_field("entries", got.entries, want.entries);
			compare_field("removed", got.removed, want.removed);
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       start;
	cmd_t       cmd;
	logic       busy;
	logic       done;
	result_t    result;
	logic       cfg_we;
	logic       cfg_index;
	logic [5:0] cfg_data;

	refcount_shadow shadow;

	reference_count_aging_table #(
		.CAPACITY(TABLE_SLOTS),
		.KEY_BITS(32)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watch the ports at each edge; everything read here holds its value from before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) shadow.write_register(cfg_index, cfg_data);
			if (done) shadow.check_result(result);
			if (start && !busy) shadow.accept_command(cmd);
		end
	end

	function automatic cmd_t make_cmd(logic op, logic [31:0] key, logic chk);
		cmd_t c;
		c.operation  = op;
		c.key        = key;
		c.check_mark = chk;
		return c;
	endfunction

	// Present one command beat after an optional pause and hold it until the block takes it.
	task automatic issue(cmd_t c, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
	endtask

	// Stop sending and wait until every outstanding result beat has come back.
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (shadow.pending_results.size() != 0 || busy);
	endtask

	// Both mark registers are written back to back, only while the block is idle.
	task automatic write_marks(logic [5:0] high, logic [5:0] low);
		cfg_we    <= 1'b1;
		cfg_index <= REG_HIGH_MARK;
		cfg_data  <= high;
		@(posedge clk);
		cfg_index <= REG_LOW_MARK;
		cfg_data  <= low;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Random traffic over a small key pool so that hits, fills and aging all happen.
	task automatic random_run(int count, int pool_size, int clean_weight);
		logic [31:0] pool [64];
		cmd_t        c;
		int          gap;
		bit          idling;
		idling = 1'b0;
		for (int i = 0; i < pool_size; i++) pool[i] = $urandom;
		pool[0] = 32'h8000_0000;
		pool[1] = 32'hFFFF_FFFF;
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0) idling = $urandom_range(0, 1);
			gap = (idling && $urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
			if ($urandom_range(0, 59) == 0) settle();
			c.operation  = ($urandom_range(1, 100) <= clean_weight) ? OP_CLEAN : OP_REFERENCE;
			c.key        = ($urandom_range(0, 9) == 0) ? $urandom
				: pool[$urandom_range(0, pool_size - 1)];
			c.check_mark = $urandom_range(0, 1);
			issue(c, gap);
		end
	endtask

	initial begin
		int pool_sizes [6];
		int clean_weights [6];
		int highs [6];
		int lows [6];
		pool_sizes    = '{24, 4, 48, 16, 40, 12};
		clean_weights = '{20, 30, 8, 25, 5, 15};
		highs         = '{32, 1, 63, 20, 63, 0};
		lows          = '{16, 0, 31, 5, 0, 0};
		shadow = new();
		arst_n    <= 1'b0;
		start     <= 1'b0;
		cmd       <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_HIGH_MARK;
		cfg_data  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset marks: empty-table cleaning, key extremes, a hit.
		issue(make_cmd(OP_CLEAN, 32'h0, 1'b1), 0);
		issue(make_cmd(OP_CLEAN, 32'h0, 1'b0), 0);
		issue(make_cmd(OP_REFERENCE, 32'h8000_0000, 1'b0), 0);
		issue(make_cmd(OP_REFERENCE, 32'h7FFF_FFFF, 1'b1), 1);
		issue(make_cmd(OP_REFERENCE, 32'h0000_0000, 1'b0), 0);
		issue(make_cmd(OP_REFERENCE, 32'hFFFF_FFFF, 1'b0), 3);
		issue(make_cmd(OP_REFERENCE, 32'h8000_0000, 1'b0), 0);
		issue(make_cmd(OP_CLEAN, 32'hFFFF_FFFF, 1'b0), 0);
		issue(make_cmd(OP_CLEAN, 32'h0, 1'b1), 0);
		settle();

		// A high mark of two refuses a key that is already present.
		write_marks(6'd2, 6'd0);
		issue(make_cmd(OP_REFERENCE, 32'h1234_5678, 1'b0), 0);
		issue(make_cmd(OP_REFERENCE, 32'h8000_0000, 1'b0), 0);
		issue(make_cmd(OP_CLEAN, 32'h0, 1'b1), 2);
		issue(make_cmd(OP_CLEAN, 32'h0, 1'b1), 0);
		settle();

		// A high mark of zero refuses every reference.
		write_marks(6'd0, 6'd31);
		issue(make_cmd(OP_REFERENCE, 32'h0000_0001, 1'b0), 0);
		issue(make_cmd(OP_CLEAN, 32'h0, 1'b0), 0);
		settle();

		// Top bit of the write data is dropped for the low mark.
		write_marks(6'd63, 6'h3F);
		issue(make_cmd(OP_CLEAN, 32'h0, 1'b1), 0);
		issue(make_cmd(OP_REFERENCE, 32'hDEAD_BEEF, 1'b1), 0);
		issue(make_cmd(OP_CLEAN, 32'h0, 1'b1), 0);
		settle();

		// Random phases, each with its own marks, key pool and mix of cleaning.
		for (int p = 0; p < 6; p++) begin
			if (p == 5) begin
				highs[p] = $urandom_range(1, 32);
				lows[p]  = $urandom_range(0, 31);
			end
			write_marks(6'(highs[p]), 6'(lows[p]));
			random_run(280, pool_sizes[p], clean_weights[p]);
			settle();
		end

		// Finish with a burst of references to one key, back to back with no pauses.
		write_marks(6'd63, 6'd0);
		while (shadow.live_count >= TABLE_SLOTS) begin
			issue(make_cmd(OP_CLEAN, 32'h0, 1'b0), 0);
			settle();
		end
		for (int n = 0; n < BURST_BEATS; n++) begin
			issue(make_cmd(OP_REFERENCE, BURST_KEY, 1'b0), 0);
		end
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (shadow.mismatches == 0 && shadow.pending_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog well beyond the slowest correct run.
	initial begin
		#10ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

@@ files.f @@
rtl/rcat_pkg.sv
rtl/rcat_cell.sv
rtl/reference_count_aging_table.sv
sim/reference_count_aging_table_test.sv
